// File: hdl/rsd_pkg.sv
// rsd_pkg: sizes, command and status codes, transfer structs and ring helpers
// for the reversible stack deque; no dependencies
package rsd_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_FLIP = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   typedef struct packed {
      logic [1:0]           command;
      logic [WORD_BITS-1:0] push_data;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] pop_data;
      logic [1:0]           status;
      logic [CNT_BITS-1:0]  occupancy;
      logic                 flipped;
   } rsp_type;

   // one memory access issued by the pointer logic
   typedef struct packed {
      logic                 wr_en;
      logic [IDX_BITS-1:0]  wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [IDX_BITS-1:0]  rd_addr;
   } mem_req_type;

   // registered result info, lined up with the ram read data
   typedef struct packed {
      logic                valid;
      logic                pop_sel;
      logic [1:0]          status;
      logic [CNT_BITS-1:0] occupancy;
      logic                flipped;
   } rsp_meta_type;

   // base + off modulo DEPTH, with off at most DEPTH - 1
   function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] off);
      logic [CNT_BITS:0] sum;
      sum = {{(CNT_BITS + 1 - IDX_BITS){1'b0}}, base} + {1'b0, off};
      if (sum >= (CNT_BITS + 1)'(DEPTH)) begin
         sum = sum - (CNT_BITS + 1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

   function automatic logic [IDX_BITS-1:0] ring_dec(input logic [IDX_BITS-1:0] base);
      logic [IDX_BITS-1:0] res;
      if (base == '0) begin
         res = IDX_BITS'(DEPTH - 1);
      end else begin
         res = base - 1'b1;
      end
      return res;
   endfunction

endpackage

// File: hdl/rsd_ram.sv
// rsd_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rsd_ctrl.sv
// rsd_ctrl: low index, count and flip mode registers; decodes each command into
// at most one ram access and the registered result info; uses rsd_pkg
module rsd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rsd_pkg::req_type      req,
   output rsd_pkg::mem_req_type  mem_req,
   output rsd_pkg::rsp_meta_type meta
);
   import rsd_pkg::*;

   logic [IDX_BITS-1:0] low_ff, low_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                flip_ff, flip_in;
   rsp_meta_type        meta_ff, meta_in;
   mem_req_type         mem_in;

   always_comb begin
      low_in   = low_ff;
      count_in = count_ff;
      flip_in  = flip_ff;
      mem_in   = '0;
      mem_in.wr_data = req.push_data;
      meta_in  = '0;

      if (accept) begin
         unique case (req.command)
            CMD_PUSH: begin
               if (count_ff == CNT_FULL) begin
                  meta_in.status = ST_FULL;
               end else if (flip_ff) begin
                  low_in         = ring_dec(low_ff);
                  mem_in.wr_en   = 1'b1;
                  mem_in.wr_addr = ring_dec(low_ff);
                  count_in       = count_ff + 1'b1;
               end else begin
                  mem_in.wr_en   = 1'b1;
                  mem_in.wr_addr = ring_add(low_ff, count_ff);
                  count_in       = count_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (count_ff == '0) begin
                  meta_in.status = ST_EMPTY;
               end else if (flip_ff) begin
                  mem_in.rd_en    = 1'b1;
                  mem_in.rd_addr  = low_ff;
                  low_in          = ring_add(low_ff, CNT_BITS'(1));
                  count_in        = count_ff - 1'b1;
                  meta_in.pop_sel = 1'b1;
               end else begin
                  mem_in.rd_en    = 1'b1;
                  mem_in.rd_addr  = ring_add(low_ff, count_ff - 1'b1);
                  count_in        = count_ff - 1'b1;
                  meta_in.pop_sel = 1'b1;
               end
            end
            CMD_FLIP: begin
               flip_in = ~flip_ff;
            end
            default: begin
               // unused code: no-op, reports unchanged state
            end
         endcase
         meta_in.valid     = 1'b1;
         meta_in.occupancy = count_in;
         meta_in.flipped   = flip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         count_ff <= '0;
         flip_ff  <= 1'b0;
         meta_ff  <= '0;
      end else begin
         low_ff   <= low_in;
         count_ff <= count_in;
         flip_ff  <= flip_in;
         meta_ff  <= meta_in;
      end
   end

   assign mem_req = mem_in;
   assign meta    = meta_ff;

endmodule

// File: hdl/reversible_stack_deque.sv
// reversible_stack_deque: top level, fixed-capacity stack with one-step reversal
// uses rsd_pkg, rsd_ctrl and rsd_ram
//
// The block takes one command per clock: busy stays low, so a command with
// start high is a transfer at every rising edge. Each command gives exactly one
// result, shown on rsp_item with rsp_strobe high for one cycle, in the cycle after
// the command transfer; the receiver cannot stall, so results never back up.
// The wait for the result is the registered read of the word ram. Words live in
// a DEPTH-entry ring; push and pop work at the high end, or at the low end
// while flipped. Push on full and pop on empty report their status and leave
// the state as it was. No clearing pass after reset: a pop only reads words a
// push has written.
module reversible_stack_deque (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rsd_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rsd_pkg::rsp_type rsp_item
);
   import rsd_pkg::*;

   logic                 accept;
   mem_req_type          mem_req;
   rsp_meta_type         meta;
   logic [WORD_BITS-1:0] rd_data;

   // no interlock needed: every ram access finishes before the next command
   // could touch the same entry
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // pointer and mode logic, result info registered alongside the ram read
   rsd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_item),
      .mem_req (mem_req),
      .meta    (meta)
   );

   // word store
   rsd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // result assembly: popped word only for a successful pop
   always_comb begin
      rsp_strobe         = meta.valid;
      rsp_item.pop_data  = meta.pop_sel ? rd_data : '0;
      rsp_item.status    = meta.status;
      rsp_item.occupancy = meta.occupancy;
      rsp_item.flipped   = meta.flipped;
   end

   // every command transfer yields a result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing result after command transfer");

   // no result without a command transfer in the previous cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("result without command transfer");

   // full status only with a full stack
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_FULL) |-> (rsp_item.occupancy == CNT_FULL))
      else $error("push on full reported with stack not full");

   // empty status only with an empty stack, and never with a word
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_EMPTY)
         |-> (rsp_item.occupancy == '0 && rsp_item.pop_data == '0))
      else $error("pop on empty reported with stack not empty");

endmodule
